/* hdl/prs_pkg.sv */
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants of the priority retransmit scheduler.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int PRIO_W    = 2;
   localparam int COUNT_W   = 8;
   localparam int DELAY_W   = 16;
   localparam int STATUS_W  = 3;

   localparam logic [COUNT_W-1:0] SEND_FOREVER = 8'd255;
   localparam logic [COUNT_W-1:0] TRIES_MAX    = 8'd255;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_ENQUEUE = 2'd1,
      CMD_STOP    = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NONE   = 3'd0,
      STAT_ACCEPT = 3'd1,
      STAT_REJECT = 3'd2,
      STAT_SENT   = 3'd3,
      STAT_WAIT   = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Pointer update for one queue level, or a clear of all levels.
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } q_upd_type;

endpackage

/* hdl/prs_desc_ram.sv */
// ----------------------------------------------------------------------------
// prs_desc_ram
// Descriptor store: single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module prs_desc_ram #(
   parameter int ADDR_W = 5,
   parameter int DATA_W = 44
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/prs_queue_ctl.sv */
// ----------------------------------------------------------------------------
// prs_queue_ctl
// Head, tail and fill of every priority queue, plus the highest-level
// non-empty search.
// ----------------------------------------------------------------------------
module prs_queue_ctl #(
   parameter int LEVELS      = 4,
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(LEVELS)-1:0]      rd_level,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rd_head,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rd_tail,
   output logic                           rd_full,
   output logic                           top_valid,
   output logic [$clog2(LEVELS)-1:0]      top_level,
   input  prs_pkg::q_upd_type             upd,
   input  logic [$clog2(LEVELS)-1:0]      upd_level
);

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [PTR_W-1:0]  head_ff [LEVELS];
   logic [PTR_W-1:0]  tail_ff [LEVELS];
   logic [FILL_W-1:0] fill_ff [LEVELS];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   assign rd_head = head_ff[rd_level];
   assign rd_tail = tail_ff[rd_level];
   assign rd_full = (fill_ff[rd_level] == FILL_W'(QUEUE_DEPTH));

   // last hit wins, so the highest non-empty level is reported
   always_comb begin
      top_valid = 1'b0;
      top_level = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (fill_ff[i] != '0) begin
            top_valid = 1'b1;
            top_level = LVL_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || upd.clear) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (upd.push) begin
         tail_ff[upd_level] <= bump(tail_ff[upd_level]);
         fill_ff[upd_level] <= FILL_W'(fill_ff[upd_level] + 1'b1);
      end else if (upd.pop && (fill_ff[upd_level] != '0)) begin
         head_ff[upd_level] <= bump(head_ff[upd_level]);
         fill_ff[upd_level] <= FILL_W'(fill_ff[upd_level] - 1'b1);
      end
   end

endmodule

/* hdl/priority_retransmit_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_retransmit_scheduler
// Per-level descriptor FIFOs with retry delay and bounded or unlimited resends.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command (tick, enqueue, stop, clear) and its fields;
//   a transfer happens when req_valid is high and req_stall is low.
//   rsp_* returns exactly one result per command, a transfer when rsp_valid
//   is high and rsp_stall is low. csr_valid/csr_ready writes retry_delay;
//   csr_ready is always high, writes belong to idle periods.
//   Each command is accepted, then executed: the accept cycle issues the
//   descriptor store read of a tick, the execute cycle does the modify,
//   write-back, queue pointer update and loads the result register.
//   req_stall is high in the execute state, so a new command is taken only
//   after the current one has executed and the result register is loaded.
//   While the receiver stalls, the result register holds and the next
//   command may still be accepted; its execute cycle waits until the
//   result register frees up.
//   Synchronous reset empties every queue, clears the delay, the current
//   frame and retry_delay. The descriptor store is not cleared; only
//   entries written by an enqueue are ever used.
// ----------------------------------------------------------------------------
module priority_retransmit_scheduler #(
   parameter int LEVELS      = 4,
   parameter int QUEUE_DEPTH = 8,
   parameter int ADDR_BITS   = 16,
   parameter int LEN_BITS    = 12
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic                 req_bus_busy,
   input  logic [1:0]           req_priority_req,
   input  logic [7:0]           req_max_sends,
   input  logic [ADDR_BITS-1:0] req_payload_addr,
   input  logic [LEN_BITS-1:0]  req_payload_len,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [ADDR_BITS-1:0] rsp_send_addr,
   output logic [LEN_BITS-1:0]  rsp_send_len,
   output logic [1:0]           rsp_send_priority,
   output logic [7:0]           rsp_send_attempt,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int RAM_AW = LVL_W + PTR_W;
   localparam int CW     = prs_pkg::COUNT_W;
   localparam int RAM_DW = ADDR_BITS + LEN_BITS + 2 * CW;

   // control
   prs_pkg::state_type state_ff, state_in;
   logic accept, out_free, fire;

   // captured command
   prs_pkg::cmd_type       cmd_ff;
   logic                   busy_ff;
   logic [1:0]             prio_ff;
   logic [CW-1:0]          maxs_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [LEN_BITS-1:0]    len_ff;
   logic [LVL_W-1:0]       sel_lvl_ff, sel_lvl_in;
   logic                   top_valid_ff;

   // scheduler state
   logic                        cur_valid_ff, cur_valid_in;
   logic [LVL_W-1:0]            cur_level_ff, cur_level_in;
   logic [prs_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic [prs_pkg::DELAY_W-1:0] retry_ff;

   // result register
   logic                        rsp_valid_ff;
   prs_pkg::status_type         status_ff, status_in;
   logic [ADDR_BITS-1:0]        s_addr_ff, s_addr_in;
   logic [LEN_BITS-1:0]         s_len_ff, s_len_in;
   logic [1:0]                  s_prio_ff, s_prio_in;
   logic [CW-1:0]               s_try_ff, s_try_in;

   // queue control
   logic [LVL_W-1:0]   q_rd_level, q_top_level;
   logic [PTR_W-1:0]   q_head, q_tail;
   logic               q_full, q_top_valid;
   prs_pkg::q_upd_type q_upd;

   // descriptor store
   logic              ram_wr_en, ram_rd_en;
   logic [RAM_AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [RAM_DW-1:0] ram_wr_data, ram_rd_data;

   logic [ADDR_BITS-1:0] d_addr;
   logic [LEN_BITS-1:0]  d_len;
   logic [CW-1:0]        d_tries, d_maxs, new_tries;
   logic                 enq_bad, send_done;

   prs_queue_ctl #(
      .LEVELS      (LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue_ctl (
      .clock     (clock),
      .reset     (reset),
      .rd_level  (q_rd_level),
      .rd_head   (q_head),
      .rd_tail   (q_tail),
      .rd_full   (q_full),
      .top_valid (q_top_valid),
      .top_level (q_top_level),
      .upd       (q_upd),
      .upd_level (sel_lvl_ff)
   );

   prs_desc_ram #(
      .ADDR_W (RAM_AW),
      .DATA_W (RAM_DW)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prs_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = prs_pkg::ST_EXEC;
            end
         end
         prs_pkg::ST_EXEC: begin
            if (fire) begin
               state_in = prs_pkg::ST_IDLE;
            end
         end
         default: state_in = prs_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall   = (state_ff != prs_pkg::ST_IDLE);
      accept      = req_valid && !req_stall;
      out_free    = !rsp_valid_ff || !rsp_stall;
      fire        = (state_ff == prs_pkg::ST_EXEC) && out_free;
      q_rd_level  = (state_ff == prs_pkg::ST_IDLE) ? q_top_level : sel_lvl_ff;
      ram_rd_en   = accept && (prs_pkg::cmd_type'(req_command) == prs_pkg::CMD_TICK);
      ram_rd_addr = {q_top_level, q_head};
   end

   // level the command works on
   always_comb begin
      unique case (prs_pkg::cmd_type'(req_command))
         prs_pkg::CMD_ENQUEUE: sel_lvl_in = LVL_W'(req_priority_req);
         prs_pkg::CMD_STOP:    sel_lvl_in = cur_level_ff;
         default:              sel_lvl_in = q_top_level;
      endcase
   end

   assign d_addr  = ram_rd_data[ADDR_BITS-1:0];
   assign d_len   = ram_rd_data[ADDR_BITS +: LEN_BITS];
   assign d_tries = ram_rd_data[ADDR_BITS + LEN_BITS +: CW];
   assign d_maxs  = ram_rd_data[ADDR_BITS + LEN_BITS + CW +: CW];

   assign new_tries = (d_tries == prs_pkg::TRIES_MAX) ? d_tries : CW'(d_tries + 1'b1);
   assign send_done = (d_maxs != prs_pkg::SEND_FOREVER) && (new_tries >= d_maxs);
   assign enq_bad   = (len_ff == '0) || (maxs_ff == '0) ||
                      !(int'(prio_ff) < LEVELS) || q_full;

   // execute
   always_comb begin
      status_in    = prs_pkg::STAT_NONE;
      s_addr_in    = '0;
      s_len_in     = '0;
      s_prio_in    = '0;
      s_try_in     = '0;
      q_upd        = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = {sel_lvl_ff,
                      (cmd_ff == prs_pkg::CMD_ENQUEUE) ? q_tail : q_head};
      ram_wr_data  = {d_maxs, new_tries, d_len, d_addr};
      cur_valid_in = cur_valid_ff;
      cur_level_in = cur_level_ff;
      delay_in     = delay_ff;
      if (fire) begin
         unique case (cmd_ff)
            prs_pkg::CMD_ENQUEUE: begin
               if (enq_bad) begin
                  status_in = prs_pkg::STAT_REJECT;
               end else begin
                  status_in   = prs_pkg::STAT_ACCEPT;
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {maxs_ff, {CW{1'b0}}, len_ff, addr_ff};
                  q_upd.push  = 1'b1;
               end
            end
            prs_pkg::CMD_STOP: begin
               if (cur_valid_ff) begin
                  q_upd.pop    = 1'b1;
                  cur_valid_in = 1'b0;
               end
            end
            prs_pkg::CMD_CLEAR: begin
               q_upd.clear  = 1'b1;
               cur_valid_in = 1'b0;
            end
            prs_pkg::CMD_TICK: begin
               priority if (delay_ff != '0) begin
                  delay_in  = prs_pkg::DELAY_W'(delay_ff - 1'b1);
                  status_in = prs_pkg::STAT_WAIT;
               end else if (!top_valid_ff) begin
                  status_in = prs_pkg::STAT_NONE;
               end else if (busy_ff) begin
                  status_in = prs_pkg::STAT_WAIT;
               end else begin
                  status_in    = prs_pkg::STAT_SENT;
                  ram_wr_en    = 1'b1;
                  s_addr_in    = d_addr;
                  s_len_in     = d_len;
                  s_prio_in    = 2'(sel_lvl_ff);
                  s_try_in     = new_tries;
                  delay_in     = retry_ff;
                  cur_level_in = sel_lvl_ff;
                  cur_valid_in = !send_done;
                  q_upd.pop    = send_done;
               end
            end
            default: status_in = prs_pkg::STAT_NONE;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prs_pkg::ST_IDLE;
         cur_valid_ff <= 1'b0;
         cur_level_ff <= '0;
         delay_ff     <= '0;
         retry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_valid_ff <= cur_valid_in;
         cur_level_ff <= cur_level_in;
         delay_ff     <= delay_in;
         if (csr_valid) begin
            retry_ff <= csr_data;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= prs_pkg::cmd_type'(req_command);
         busy_ff      <= req_bus_busy;
         prio_ff      <= req_priority_req;
         maxs_ff      <= req_max_sends;
         addr_ff      <= req_payload_addr;
         len_ff       <= req_payload_len;
         sel_lvl_ff   <= sel_lvl_in;
         top_valid_ff <= q_top_valid;
      end
      if (fire) begin
         status_ff <= status_in;
         s_addr_ff <= s_addr_in;
         s_len_ff  <= s_len_in;
         s_prio_ff <= s_prio_in;
         s_try_ff  <= s_try_in;
      end
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_send_addr     = s_addr_ff;
   assign rsp_send_len      = s_len_ff;
   assign rsp_send_priority = s_prio_ff;
   assign rsp_send_attempt  = s_try_ff;

endmodule

/* hdl/prs_checker.sv */
// ----------------------------------------------------------------------------
// prs_checker
// Port-level checks of the priority retransmit scheduler.
// ----------------------------------------------------------------------------
module prs_checker #(
   parameter int ADDR_BITS   = 16,
   parameter int LEN_BITS    = 12
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [2:0]           rsp_status,
   input logic [ADDR_BITS-1:0] rsp_send_addr,
   input logic [LEN_BITS-1:0]  rsp_send_len,
   input logic [1:0]           rsp_send_priority,
   input logic [7:0]           rsp_send_attempt
);

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_send_addr) && $stable(rsp_send_len) &&
                                 $stable(rsp_send_priority) && $stable(rsp_send_attempt))
      else $error("stalled result changed");

   // one command in flight: the cycle after a transfer in is the execute cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("command accepted during execute");

   // send fields stay zero unless a frame was sent
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != prs_pkg::STAT_SENT) |->
         (rsp_send_addr == '0) && (rsp_send_len == '0) &&
         (rsp_send_priority == '0) && (rsp_send_attempt == '0))
      else $error("send fields set without a send");

   // a sent frame carries a nonzero attempt and a nonzero length
   a_sent_attempt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == prs_pkg::STAT_SENT) |->
         (rsp_send_attempt != '0) && (rsp_send_len != '0))
      else $error("sent frame with zero attempt or length");

endmodule

bind priority_retransmit_scheduler prs_checker #(
   .ADDR_BITS   (ADDR_BITS),
   .LEN_BITS    (LEN_BITS)
) u_prs_checker (.*);
